[hdl/pwgc_pkg.sv]
// shared types, constants and knee scaling for the piecewise-linear gamma curve
package pwgc_pkg;

   localparam int NUM_KNEES  = 8;
   localparam int KNEE_AW    = $clog2(NUM_KNEES);
   localparam int LEVEL_W    = 12;
   localparam int CODE_W     = 8;
   localparam int KNEE_W     = 2 * CODE_W;
   localparam int PROD_W     = 2 * LEVEL_W;
   localparam int DATA_W     = 16;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int DIV_STAGES = LEVEL_W;

   // reciprocal of 17 in 12 fractional bits, exact for 8-bit codes
   localparam logic [15:0] RECIP_17 = 16'd241;

   localparam logic [KNEE_W-1:0] KNEE_RESET [NUM_KNEES] = '{
      16'h2020, 16'h4040, 16'h6060, 16'h8080,
      16'hA0A0, 16'hC0C0, 16'hDEDE, 16'hFFFF
   };

   // one classified word handed from the front to the back
   typedef struct packed {
      logic               hit;
      logic               interp;
      logic               neg;
      logic [LEVEL_W-1:0] base;
      logic [LEVEL_W-1:0] dx;
      logic [LEVEL_W-1:0] dy_mag;
      logic [LEVEL_W-1:0] den;
   } seg_type;

   // code*4095/255 = 16*code + code/17
   function automatic logic [LEVEL_W-1:0] scale_code(input logic [CODE_W-1:0] code);
      logic [15:0] prod;
      prod = 16'(code) * RECIP_17;
      return {code, 4'b0000} + LEVEL_W'(prod[15:12]);
   endfunction

endpackage

[hdl/pwgc_front.sv]
// knee registers and segment classification of incoming levels
module pwgc_front
   import pwgc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [KNEE_AW-1:0]  csr_index,
   input  logic [KNEE_W-1:0]   csr_data,
   input  logic [LEVEL_W-1:0]  level,
   output seg_type             seg
);

   logic [LEVEL_W-1:0] knee_x_ff [NUM_KNEES];
   logic [LEVEL_W-1:0] knee_y_ff [NUM_KNEES];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KNEES; i++) begin
            knee_x_ff[i] <= scale_code(KNEE_RESET[i][CODE_W-1:0]);
            knee_y_ff[i] <= scale_code(KNEE_RESET[i][KNEE_W-1:CODE_W]);
         end
      end else if (csr_valid) begin
         knee_x_ff[csr_index] <= scale_code(csr_data[CODE_W-1:0]);
         knee_y_ff[csr_index] <= scale_code(csr_data[KNEE_W-1:CODE_W]);
      end
   end

   always_comb begin
      logic [LEVEL_W-1:0] px, py, sx0, sy0, sx1, sy1;
      logic               hit;
      hit = 1'b0;
      sx0 = '0;
      sy0 = '0;
      sx1 = '0;
      sy1 = '0;
      // highest covering segment wins
      for (int i = 0; i < NUM_KNEES; i++) begin
         px = (i == 0) ? '0 : knee_x_ff[(i == 0) ? 0 : i - 1];
         py = (i == 0) ? '0 : knee_y_ff[(i == 0) ? 0 : i - 1];
         if (level >= px && level <= knee_x_ff[i]) begin
            hit = 1'b1;
            sx0 = px;
            sy0 = py;
            sx1 = knee_x_ff[i];
            sy1 = knee_y_ff[i];
         end
      end
      seg.hit    = hit;
      seg.interp = hit && (sx1 != sx0);
      seg.neg    = sy1 < sy0;
      seg.den    = sx1 - sx0;
      if (!hit) begin
         seg.base   = '0;
         seg.dx     = '0;
         seg.dy_mag = '0;
      end else if (sx1 == sx0) begin
         // zero-width segment gives its end knee
         seg.base   = sy1;
         seg.dx     = '0;
         seg.dy_mag = '0;
      end else begin
         seg.base   = sy0;
         seg.dx     = level - sx0;
         seg.dy_mag = (sy1 < sy0) ? (sy0 - sy1) : (sy1 - sy0);
      end
   end

endmodule

[hdl/pwgc_fifo.sv]
// short queue of classified words between front and back
module pwgc_fifo
   import pwgc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  seg_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output seg_type pop_data
);

   seg_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;

   assign full      = count_ff == (FIFO_AW+1)'(FIFO_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/pwgc_back.sv]
// multiply, pipelined restoring divide and output register
module pwgc_back
   import pwgc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                seg_valid,
   input  seg_type             seg,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [LEVEL_W-1:0]  level_out,
   output logic                covered
);

   typedef struct packed {
      logic               hit;
      logic               interp;
      logic               neg;
      logic [LEVEL_W-1:0] base;
      logic [LEVEL_W-1:0] den;
      logic [PROD_W-1:0]  rem;
      logic [LEVEL_W-1:0] quo;
   } div_type;

   div_type            stage_ff [DIV_STAGES+1];
   div_type            stage_in [DIV_STAGES+1];
   logic               valid_ff [DIV_STAGES+1];
   logic               out_valid_ff;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               covered_ff;
   logic               advance;

   // whole pipe moves unless the output word is held
   assign advance    = !out_valid_ff || rsp_tready;
   assign pop        = advance && seg_valid;
   assign rsp_tvalid = out_valid_ff;
   assign level_out  = level_ff;
   assign covered    = covered_ff;

   always_comb begin
      logic [PROD_W-1:0] divisor;
      stage_in[0].hit    = seg.hit;
      stage_in[0].interp = seg.interp;
      stage_in[0].neg    = seg.neg;
      stage_in[0].base   = seg.base;
      stage_in[0].den    = seg.den;
      stage_in[0].rem    = PROD_W'(seg.dy_mag) * PROD_W'(seg.dx);
      stage_in[0].quo    = '0;
      // one quotient bit per stage, msb first
      for (int j = 1; j <= DIV_STAGES; j++) begin
         stage_in[j] = stage_ff[j-1];
         divisor     = PROD_W'(stage_ff[j-1].den) << (DIV_STAGES - j);
         if (stage_ff[j-1].rem >= divisor) begin
            stage_in[j].rem                  = stage_ff[j-1].rem - divisor;
            stage_in[j].quo[DIV_STAGES - j]  = 1'b1;
         end
      end
   end

   always_comb begin
      if (!stage_ff[DIV_STAGES].interp) begin
         level_in = stage_ff[DIV_STAGES].base;
      end else if (stage_ff[DIV_STAGES].neg) begin
         level_in = stage_ff[DIV_STAGES].base - stage_ff[DIV_STAGES].quo;
      end else begin
         level_in = stage_ff[DIV_STAGES].base + stage_ff[DIV_STAGES].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= DIV_STAGES; j++) begin
            valid_ff[j] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= seg_valid;
         for (int j = 1; j <= DIV_STAGES; j++) begin
            valid_ff[j] <= valid_ff[j-1];
         end
         out_valid_ff <= valid_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j <= DIV_STAGES; j++) begin
            stage_ff[j] <= stage_in[j];
         end
         level_ff   <= level_in;
         covered_ff <= stage_ff[DIV_STAGES].hit;
      end
   end

endmodule

[hdl/piecewise_linear_gamma_curve.sv]
// an accepted req word goes through the queue, the divider stage registers and the output register to rsp_tvalid
// throughput: one level per cycle unless rsp is stalled; the 12-stage divider is pipelined, one quotient bit a stage
// a four-word queue lets the front keep taking words while rsp is stalled
// reset clears all valid state and loads the identity knee set
// top level of the piecewise-linear gamma curve
module piecewise_linear_gamma_curve
   import pwgc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [DATA_W-1:0]   req_tdata,   // [11:0] level_in
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,   // [11:0] level_out
   output logic                rsp_tuser,   // [0] covered
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [KNEE_AW-1:0]  csr_index,
   input  logic [KNEE_W-1:0]   csr_data
);

   seg_type            front_seg;
   seg_type            queue_seg;
   logic               queue_full;
   logic               queue_valid;
   logic               queue_pop;
   logic [LEVEL_W-1:0] level_out;

   assign req_tready = !queue_full;
   assign rsp_tdata  = DATA_W'(level_out);

   pwgc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .level     (req_tdata[LEVEL_W-1:0]),
      .seg       (front_seg)
   );

   pwgc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && !queue_full),
      .push_data (front_seg),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_valid),
      .pop_data  (queue_seg)
   );

   pwgc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .seg_valid  (queue_valid),
      .seg        (queue_seg),
      .pop        (queue_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .level_out  (level_out),
      .covered    (rsp_tuser)
   );

endmodule

[hdl/pwgc_checker.sv]
// port-level checks on the gamma curve block, bound to the top level
module pwgc_checker
   import pwgc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tuser
);

   // a held word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   // uncovered levels map to zero
   a_uncovered_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[LEVEL_W-1:0] == '0)
      else $error("uncovered level gave nonzero output");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[DATA_W-1:LEVEL_W] == '0)
      else $error("rsp_tdata padding not zero");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

endmodule

bind piecewise_linear_gamma_curve pwgc_checker u_pwgc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[dv/piecewise_linear_gamma_curve_tb.sv]
// self-checking testbench for the piecewise-linear gamma curve stream block
module piecewise_linear_gamma_curve_tb
   import pwgc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FULL_LEVEL  = 4095;
   localparam int CODE_FULL   = 255;
   localparam int LATENCY     = 14;
   localparam int QUIET_LIMIT = 2000;
   localparam int PER_CURVE   = 53;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_in;
      logic [LEVEL_W-1:0] level_out;
      logic               covered;
   } mapped_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata  = '0;   // [11:0] level_in
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [DATA_W-1:0]   rsp_tdata;         // [11:0] level_out
   logic                rsp_tuser;         // [0] covered
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [KNEE_AW-1:0]  csr_index  = '0;
   logic [KNEE_W-1:0]   csr_data   = '0;

   logic [KNEE_W-1:0]   knee_shadow [NUM_KNEES];
   logic [KNEE_W-1:0]   knee_plan [NUM_KNEES];
   mapped_type          mapped_q [$];
   int                  send_idle_pct = 0;
   int                  rsp_idle_pct  = 0;
   int                  n_mismatch    = 0;
   int                  quiet_cycles  = 0;

   always #5 clock = ~clock;

   piecewise_linear_gamma_curve uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   function automatic int knee_level(input logic [CODE_W-1:0] code);
      return (int'(code) * FULL_LEVEL) / CODE_FULL;
   endfunction

   // walk all segments in order so the highest covering one wins
   function automatic mapped_type gamma_map(input logic [LEVEL_W-1:0] lv);
      int         x, px, py, qx, qy, y;
      mapped_type r;
      x = int'(lv);
      px = 0;
      py = 0;
      r = '0;
      r.level_in = lv;
      for (int i = 0; i < NUM_KNEES; i++) begin
         qx = knee_level(knee_shadow[i][CODE_W-1:0]);
         qy = knee_level(knee_shadow[i][KNEE_W-1:CODE_W]);
         if (x >= px && x <= qx) begin
            if (qx == px) begin
               y = qy;
            end else begin
               y = py + ((qy - py) * (x - px)) / (qx - px);
            end
            r.level_out = LEVEL_W'(y);
            r.covered   = 1'b1;
         end
         px = qx;
         py = qy;
      end
      return r;
   endfunction

   task automatic send_level(input logic [LEVEL_W-1:0] lv);
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(lv);
      do @(posedge clock); while (!req_tready);
      mapped_q.push_back(gamma_map(lv));
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // hold off the sender until every mapped word is back
   task automatic idle_sender();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (mapped_q.size() != 0) @(posedge clock);
   endtask

   task automatic load_knees();
      for (int i = 0; i < NUM_KNEES; i++) begin
         csr_valid <= 1'b1;
         csr_index <= KNEE_AW'(i);
         csr_data  <= knee_plan[i];
         do @(posedge clock); while (!csr_ready);
         knee_shadow[i] = knee_plan[i];
      end
      csr_valid <= 1'b0;
   endtask

   task automatic plan_curve(input int shape, input int phase);
      logic [CODE_W-1:0] cx [NUM_KNEES];
      logic [CODE_W-1:0] cy [NUM_KNEES];
      logic [CODE_W-1:0] t;
      for (int i = 0; i < NUM_KNEES; i++) begin
         cx[i] = CODE_W'($urandom);
         cy[i] = CODE_W'($urandom);
      end
      // sort x so that segments chain end to end
      for (int i = 0; i < NUM_KNEES; i++)
         for (int j = 0; j < NUM_KNEES - 1 - i; j++)
            if (cx[j] > cx[j+1]) begin
               t = cx[j]; cx[j] = cx[j+1]; cx[j+1] = t;
               if (shape == 0) begin
                  t = cy[j]; cy[j] = cy[j+1]; cy[j+1] = t;
               end
            end
      if (shape == 0) begin
         for (int i = 0; i < NUM_KNEES; i++)
            for (int j = 0; j < NUM_KNEES - 1 - i; j++)
               if (cy[j] > cy[j+1]) begin
                  t = cy[j]; cy[j] = cy[j+1]; cy[j+1] = t;
               end
      end
      if (shape == 3) begin
         // a few zero-width segments
         cx[$urandom_range(NUM_KNEES-1, 1)] = cx[0];
         for (int i = 1; i < NUM_KNEES; i++)
            if ($urandom_range(3) == 0) cx[i] = cx[i-1];
      end
      for (int i = 0; i < NUM_KNEES; i++) begin
         case (shape)
            1:       knee_plan[i] = KNEE_W'($urandom);
            2: begin
               case (phase)
                  0:       knee_plan[i] = '0;
                  1:       knee_plan[i] = '1;
                  default: knee_plan[i] = i[0] ? 16'hFF00 : 16'h00FF;
               endcase
            end
            default: knee_plan[i] = {cy[i], cx[i]};
         endcase
      end
   endtask

   task automatic test_reset_curve();
      send_idle_pct = 26;
      rsp_idle_pct  = 73;
      send_level(12'd0);
      send_level(12'd1);
      send_level(12'd512);
      send_level(12'd513);
      send_level(12'd514);
      send_level(12'd1365);
      send_level(12'd2048);
      send_level(12'd2730);
      send_level(12'd4094);
      send_level(12'd4095);
      idle_sender();
   endtask

   // zero-width, backward, falling and overlapping segments plus an uncovered tail
   task automatic test_special_segments();
      knee_plan[0] = 16'h8000;
      knee_plan[1] = 16'h1040;
      knee_plan[2] = 16'hFF20;
      knee_plan[3] = 16'h0060;
      knee_plan[4] = 16'hC060;
      knee_plan[5] = 16'h4080;
      knee_plan[6] = 16'h9070;
      knee_plan[7] = 16'hFFC0;
      load_knees();
      send_level(12'd0);
      send_level(12'd1);
      send_level(12'd300);
      send_level(12'd513);
      send_level(12'd514);
      send_level(12'd1000);
      send_level(12'd1027);
      send_level(12'd1541);
      send_level(12'd1542);
      send_level(12'd1800);
      send_level(12'd2055);
      send_level(12'd3083);
      send_level(12'd3084);
      send_level(12'd4095);
      idle_sender();
   endtask

   task automatic test_random_curves(input int sender_idle, input int receiver_idle,
                                     input int phase);
      int lv;
      int k;
      send_idle_pct = sender_idle;
      rsp_idle_pct  = receiver_idle;
      for (int shape = 0; shape < 4; shape++) begin
         plan_curve(shape, phase);
         load_knees();
         for (int n = 0; n < PER_CURVE; n++) begin
            if (n == PER_CURVE / 2) idle_sender();
            if ($urandom_range(9) < 3) begin
               // land on or next to a knee
               k  = $urandom_range(NUM_KNEES-1);
               lv = knee_level(knee_shadow[k][CODE_W-1:0]) + $urandom_range(2) - 1;
               if (lv < 0) lv = 0;
               if (lv > FULL_LEVEL) lv = FULL_LEVEL;
            end else begin
               lv = $urandom_range(FULL_LEVEL);
            end
            send_level(LEVEL_W'(lv));
         end
         idle_sender();
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin : check_rsp
      mapped_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mapped_q.size() == 0) begin
            $display("%0t: unexpected rsp word, expected none, actual level_out %0d covered %0b",
                     $time, rsp_tdata, rsp_tuser);
            n_mismatch++;
         end else begin
            want = mapped_q.pop_front();
            if (rsp_tdata !== DATA_W'(want.level_out)) begin
               $display("%0t: level_out for level_in %0d, expected %0d, actual %0d",
                        $time, want.level_in, want.level_out, rsp_tdata);
               n_mismatch++;
            end
            if (rsp_tuser !== want.covered) begin
               $display("%0t: covered for level_in %0d, expected %0b, actual %0b",
                        $time, want.level_in, want.covered, rsp_tuser);
               n_mismatch++;
            end
         end
      end
   end

   // nothing moving on any channel for too long means the block hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("piecewise_linear_gamma_curve regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < NUM_KNEES; i++) knee_shadow[i] = KNEE_RESET[i];
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_curve();
      test_special_segments();
      test_random_curves(26, 73, 0);
      test_random_curves(73, 26, 1);
      test_random_curves(0, 0, 2);
      idle_sender();
      repeat (2 * LATENCY) @(posedge clock);
      if (n_mismatch == 0) begin
         $display("piecewise_linear_gamma_curve regression: pass");
      end else begin
         $display("piecewise_linear_gamma_curve regression: fail");
      end
      $finish;
   end

endmodule
